>>> src/stlb_pkg.sv
// Shared command codes and controller/datapath interface types for the table search block.
package stlb_pkg;

  // Command field codes
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic write;        // store entry_value at entry_index
    logic load;         // latch key and saturated range
    logic probe_first;  // issue first table read from the range registers
    logic probe_step;   // compare read data, narrow range, issue next read
    logic emit;         // load the output register
    logic emit_step;    // output source: 1 = narrowed upper end, 0 = hi register
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic empty_range;  // lo >= hi in the range registers
    logic done_step;    // narrowed range is empty after this probe
    logic out_busy;     // output register holds an item that is stalled
  } dp_stat_t;

endpackage

>>> src/stlb_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module stlb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> src/stlb_datapath.sv
// Datapath: table RAM, range registers, probe compare and output register.
module stlb_datapath #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  stlb_pkg::dp_cmd_t  cmd,
  output stlb_pkg::dp_stat_t stat,
  input  logic [5:0]       entry_index,
  input  logic [15:0]      entry_value,
  input  logic [15:0]      search_key,
  input  logic [6:0]       range_low,
  input  logic [6:0]       range_high,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [6:0]       found_position
);
  import stlb_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int PW = $clog2(TABLE_DEPTH + 1);
  localparam int IW = (PW > 6) ? PW : 6;
  localparam int CW = (PW > 7) ? PW : 7;
  localparam logic [IW-1:0] DEPTH_I = IW'(TABLE_DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  logic [15:0]   key;
  logic [PW-1:0] lo;
  logic [PW-1:0] hi;
  logic [AW-1:0] mid;
  logic [15:0]   rdata;

  logic [IW-1:0] idx_ext;
  logic          wr_en;
  logic [CW-1:0] low_ext;
  logic [CW-1:0] high_ext;
  logic [PW-1:0] lo_sat;
  logic [PW-1:0] hi_sat;
  logic [PW:0]   sum_first;
  logic [AW-1:0] mid_first;
  logic [PW-1:0] mid_pos;
  logic [PW-1:0] lo_next;
  logic [PW-1:0] hi_next;
  logic [PW:0]   sum_next;
  logic [AW-1:0] mid_next;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [PW-1:0] res_pos;
  logic [CW-1:0] res_ext;

  // Drop writes beyond the table
  assign idx_ext = IW'(entry_index);
  assign wr_en   = cmd.write && (idx_ext < DEPTH_I);

  // Saturate range ends to the table depth
  assign low_ext  = CW'(range_low);
  assign high_ext = CW'(range_high);
  always_comb begin
    lo_sat = (low_ext > DEPTH_C) ? PW'(TABLE_DEPTH) : low_ext[PW-1:0];
    hi_sat = (high_ext > DEPTH_C) ? PW'(TABLE_DEPTH) : high_ext[PW-1:0];
  end

  // Midpoint of the held range
  assign sum_first = {1'b0, lo} + {1'b0, hi};
  assign mid_first = sum_first[AW:1];

  // Narrow the range by the probed entry, then take the next midpoint
  assign mid_pos = PW'(mid);
  always_comb begin
    if (rdata < key) begin
      lo_next = mid_pos + PW'(1);
      hi_next = hi;
    end else begin
      lo_next = lo;
      hi_next = mid_pos;
    end
  end
  assign sum_next = {1'b0, lo_next} + {1'b0, hi_next};
  assign mid_next = sum_next[AW:1];

  assign rd_en   = cmd.probe_first || cmd.probe_step;
  assign rd_addr = cmd.probe_step ? mid_next : mid_first;

  stlb_ram #(
    .WIDTH (16),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (idx_ext[AW-1:0]),
    .wdata (entry_value),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  // Range and probe registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key <= search_key;
      lo  <= lo_sat;
      hi  <= hi_sat;
    end else if (cmd.probe_step) begin
      lo <= lo_next;
      hi <= hi_next;
    end
    if (rd_en) begin
      mid <= rd_addr;
    end
  end

  // Output register
  assign res_pos = cmd.emit_step ? hi_next : hi;
  assign res_ext = CW'(res_pos);
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (cmd.emit) begin
      found_position <= res_ext[6:0];
    end
  end

  assign stat.empty_range = !(lo < hi);
  assign stat.done_step   = !(lo_next < hi_next);
  assign stat.out_busy    = out_valid && out_stall;

endmodule

>>> src/stlb_ctrl.sv
// Controller: state machine that sequences writes, range setup and table probes.
module stlb_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               command,
  input  stlb_pkg::dp_stat_t stat,
  output stlb_pkg::dp_cmd_t  cmd
);
  import stlb_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_PROBE,
    ST_HOLD
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && (state == ST_IDLE);

  // Next state and datapath commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (command == CMD_SEARCH) begin
            cmd.load   = 1'b1;
            state_next = ST_CHECK;
          end else begin
            cmd.write = 1'b1;
          end
        end
      end
      ST_CHECK: begin
        if (stat.empty_range) begin
          if (!stat.out_busy) begin
            cmd.emit   = 1'b1;
            state_next = ST_IDLE;
          end else begin
            state_next = ST_HOLD;
          end
        end else begin
          cmd.probe_first = 1'b1;
          state_next      = ST_PROBE;
        end
      end
      ST_PROBE: begin
        cmd.probe_step = 1'b1;
        if (stat.done_step) begin
          if (!stat.out_busy) begin
            cmd.emit      = 1'b1;
            cmd.emit_step = 1'b1;
            state_next    = ST_IDLE;
          end else begin
            state_next = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        if (!stat.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> src/sorted_table_lower_bound_search.sv
// Top level of the sorted-table lower-bound search block.
//
// Input channel (in_valid / in_stall) carries one command item. A write item
// (command = 0) stores entry_value at entry_index and gives no
// result; indexes at or beyond TABLE_DEPTH are dropped. A search item
// (command = 1) returns on the output channel the first position in
// [range_low, range_high) whose entry is not less than search_key, or the
// upper end when none is; both ends are saturated to TABLE_DEPTH.
// A search has a setup step that checks the range, then probes the table one
// entry at a time through the single read port of the table RAM, so a range of
// n entries needs floor(log2(n))+1 probes at most; the result is then
// registered, or held in the controller until the output register frees.
// The block takes one item at a time; in_stall is high while a search runs,
// so the next item is taken only after the search ends, and in the cycle
// after a write.
// The output register lets a new item in while a result waits; if the
// receiver still stalls when the next search ends, that search holds until
// the register frees. Reset clears the controller and the output valid; the
// table contents are undefined until written.
module sorted_table_lower_bound_search #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        command,
  input  logic [5:0]  entry_index,
  input  logic [15:0] entry_value,
  input  logic [15:0] search_key,
  input  logic [6:0]  range_low,
  input  logic [6:0]  range_high,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [6:0]  found_position
);
  import stlb_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  stlb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .command  (command),
    .stat     (stat),
    .cmd      (cmd)
  );

  stlb_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .entry_index    (entry_index),
    .entry_value    (entry_value),
    .search_key     (search_key),
    .range_low      (range_low),
    .range_high     (range_high),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .found_position (found_position)
  );

endmodule

>>> src/stlb_checker.sv
// Port-level assertions for the search block and their bind to the top level.
module stlb_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       command,
  input logic       out_valid,
  input logic       out_stall,
  input logic [6:0] found_position
);
  import stlb_pkg::*;

  // No result is pending right after reset
  a_reset_clear: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid set after reset");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(found_position))
    else $error("stalled result changed");

  // An accepted search keeps the block busy in the next cycle
  a_search_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (command == CMD_SEARCH) |=> in_stall)
    else $error("search did not occupy the block");

  // A write item never produces a result
  a_write_silent: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (command == CMD_WRITE) && !out_valid |=> !out_valid)
    else $error("write produced a result");

endmodule

bind sorted_table_lower_bound_search stlb_checker u_stlb_checker (.*);

>>> tb/tb_sorted_table_lower_bound_search.sv
// Self-checking testbench for the sorted-table lower-bound search block.
module tb_sorted_table_lower_bound_search;
  timeunit 1ns;
  timeprecision 1ps;

  import stlb_pkg::*;

  localparam int DEPTH      = 64;
  localparam int IDLE_LIMIT = 3000;
  localparam int FILL_ROUNDS = 4;
  localparam int MIXED_ITEMS = 93;

  typedef struct packed {
    logic        cmd;
    logic [5:0]  idx;
    logic [15:0] value;
    logic [15:0] key;
    logic [6:0]  lo;
    logic [6:0]  hi;
    logic        drain_first;
  } table_cmd_t;

  typedef struct packed {
    logic [6:0]  pos;
    logic [15:0] key;
    logic [6:0]  lo;
    logic [6:0]  hi;
  } lookup_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        command = CMD_WRITE;
  logic [5:0]  entry_index = '0;
  logic [15:0] entry_value = '0;
  logic [15:0] search_key = '0;
  logic [6:0]  range_low = '0;
  logic [6:0]  range_high = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [6:0]  found_position;

  // Stimulus and prediction state
  table_cmd_t  cmd_queue[$];
  lookup_t     expected_lookups[$];
  logic [15:0] table_model[DEPTH];
  logic [15:0] plan_words[DEPTH];
  logic        in_took = 1'b0;
  logic        out_took = 1'b0;
  int          mismatch_count = 0;
  int          lookups_checked = 0;
  int          writes_queued = 0;
  int          searches_queued = 0;
  int          idle_cycles = 0;

  // Driver and receiver pacing
  logic        tx_valid_next;
  int          tx_gap = 0;
  int          tx_calm = 0;
  int          rx_wait = 0;
  int          rx_calm = 0;
  int          rx_hold = 0;
  int          results_seen = 0;

  sorted_table_lower_bound_search #(
    .TABLE_DEPTH(DEPTH)
  ) u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .command       (command),
    .entry_index   (entry_index),
    .entry_value   (entry_value),
    .search_key    (search_key),
    .range_low     (range_low),
    .range_high    (range_high),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .found_position(found_position)
  );

  always #6 clk = ~clk;

  // Halve the saturated range until the first entry not below the key
  function automatic logic [6:0] predict_lower_bound(input logic [15:0] key,
                                                     input logic [6:0] lo_in,
                                                     input logic [6:0] hi_in);
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    lo = (lo_in > DEPTH) ? DEPTH : lo_in;
    hi = (hi_in > DEPTH) ? DEPTH : hi_in;
    while (lo < hi) begin
      mid = (lo + hi) >> 1;
      if (mid >= DEPTH) break;
      if (table_model[mid] < key) lo = mid + 1;
      else hi = mid;
    end
    return hi[6:0];
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("[%0t] MISMATCH: %s", $time, what);
  endtask

  task automatic queue_write(input int idx, input logic [15:0] value, input bit drain);
    table_cmd_t c;
    c.cmd         = CMD_WRITE;
    c.idx         = idx[5:0];
    c.value       = value;
    c.key         = 16'($urandom);
    c.lo          = 7'($urandom);
    c.hi          = 7'($urandom);
    c.drain_first = drain;
    plan_words[idx] = value;
    cmd_queue.push_back(c);
    writes_queued++;
  endtask

  task automatic queue_search(input logic [15:0] key, input int lo, input int hi);
    table_cmd_t c;
    c.cmd         = CMD_SEARCH;
    c.idx         = 6'($urandom);
    c.value       = 16'($urandom);
    c.key         = key;
    c.lo          = lo[6:0];
    c.hi          = hi[6:0];
    c.drain_first = 1'b0;
    cmd_queue.push_back(c);
    searches_queued++;
  endtask

  // Rewrite the whole table in a shuffled order with one of four shapes
  task automatic refill_table(input int shape);
    int          order[DEPTH];
    logic [15:0] words[DEPTH];
    int          acc;
    int          j;
    int          t;
    logic [15:0] flat;
    acc  = $urandom_range(0, 40);
    flat = 16'($urandom_range(1, 65534));
    for (int i = 0; i < DEPTH; i++) begin
      case (shape)
        0: begin
          words[i] = (acc > 65535) ? 16'hFFFF : acc[15:0];
          acc += ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 1500);
        end
        1: words[i] = 16'(i * 1040 + $urandom_range(0, 1039));
        2: words[i] = 16'((i >> 4) * 21845);
        default: words[i] = flat;
      endcase
      order[i] = i;
    end
    if (shape == 1) begin
      words[0]         = 16'h0000;
      words[DEPTH - 1] = 16'hFFFF;
    end
    for (int i = DEPTH - 1; i > 0; i--) begin
      j        = $urandom_range(0, i);
      t        = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    for (int i = 0; i < DEPTH; i++)
      queue_write(order[i], words[order[i]], i == 0);
  endtask

  // Mostly searches with table-derived keys, plus in-order and noisy rewrites
  task automatic queue_mixed(input int count);
    int          sel;
    int          lo;
    int          hi;
    int          idx;
    logic [15:0] key;
    logic [15:0] floor_val;
    logic [15:0] ceil_val;
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(0, 19);
      if (sel < 3) begin
        idx       = $urandom_range(0, DEPTH - 1);
        floor_val = (idx > 0) ? plan_words[idx - 1] : 16'h0000;
        ceil_val  = (idx < DEPTH - 1) ? plan_words[idx + 1] : 16'hFFFF;
        if (floor_val <= ceil_val)
          queue_write(idx, 16'($urandom_range(ceil_val, floor_val)), 1'b0);
        else queue_write(idx, 16'($urandom), 1'b0);
      end else if (sel == 3) begin
        queue_write($urandom_range(0, DEPTH - 1), 16'($urandom), 1'b0);
      end else begin
        sel = $urandom_range(0, 19);
        key = plan_words[$urandom_range(0, DEPTH - 1)];
        if (sel < 4) key = key + 16'd1;
        else if (sel < 7) key = key - 16'd1;
        else if (sel < 10) key = 16'($urandom);
        else if (sel < 12) key = (sel == 10) ? 16'h0000 : 16'hFFFF;
        sel = $urandom_range(0, 19);
        if (sel < 12) begin
          lo = $urandom_range(0, DEPTH);
          hi = $urandom_range(lo, DEPTH);
        end else if (sel < 14) begin
          lo = $urandom_range(0, 8);
          hi = $urandom_range(DEPTH, 127);
        end else if (sel < 16) begin
          hi = $urandom_range(0, DEPTH - 1);
          lo = $urandom_range(hi + 1, 127);
        end else begin
          lo = $urandom_range(0, 127);
          hi = $urandom_range(0, 127);
        end
        queue_search(key, lo, hi);
      end
    end
  endtask

  // Drive the next item at the falling edge; hold it until accepted
  always @(negedge clk) begin
    tx_valid_next = in_valid;
    if (in_valid && in_took) begin
      tx_valid_next = 1'b0;
      void'(cmd_queue.pop_front());
      if (tx_calm > 0) tx_calm--;
      else if ($urandom_range(0, 15) == 0) tx_calm = $urandom_range(8, 30);
      tx_gap = (tx_calm > 0) ? 0 : $urandom_range(0, 8);
    end
    if (!rst && !tx_valid_next && cmd_queue.size() != 0) begin
      if (tx_gap > 0) begin
        tx_gap--;
      end else if (!cmd_queue[0].drain_first || expected_lookups.size() == 0) begin
        command       <= cmd_queue[0].cmd;
        entry_index   <= cmd_queue[0].idx;
        entry_value   <= cmd_queue[0].value;
        search_key    <= cmd_queue[0].key;
        range_low     <= cmd_queue[0].lo;
        range_high    <= cmd_queue[0].hi;
        tx_valid_next = 1'b1;
      end
    end
    in_valid <= tx_valid_next;
  end

  // Stall the result channel per result, with two long hold-offs
  always @(negedge clk) begin
    if (out_took) begin
      results_seen++;
      if (results_seen == 40 || results_seen == 200) rx_hold = 90;
      if (rx_calm > 0) rx_calm--;
      else if ($urandom_range(0, 15) == 0) rx_calm = $urandom_range(8, 30);
      rx_wait = (rx_calm > 0) ? 0 : $urandom_range(0, 8);
    end
    if (rx_hold > 0) begin
      rx_hold--;
      out_stall <= 1'b1;
    end else if (rx_wait > 0) begin
      rx_wait--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Predict on accepted items, check accepted results against the oldest lookup
  always @(posedge clk) begin
    lookup_t want;
    in_took  <= !rst && in_valid && !in_stall;
    out_took <= !rst && out_valid && !out_stall;
    if (!rst && in_valid && !in_stall) begin
      if (command == CMD_WRITE) begin
        table_model[entry_index] = entry_value;
      end else begin
        want.pos = predict_lower_bound(search_key, range_low, range_high);
        want.key = search_key;
        want.lo  = range_low;
        want.hi  = range_high;
        expected_lookups.push_back(want);
      end
    end
    if (!rst && out_valid && !out_stall) begin
      lookups_checked++;
      if (expected_lookups.size() == 0) begin
        report_mismatch($sformatf("result %0d with no search pending", found_position));
      end else begin
        want = expected_lookups.pop_front();
        if (found_position !== want.pos)
          report_mismatch($sformatf("key %h range [%0d,%0d): found_position %0d, want %0d",
                                    want.key, want.lo, want.hi, found_position, want.pos));
      end
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[%0t] timeout: no item moved for %0d cycles", $time, IDLE_LIMIT);
      $display("** sorted_table_lower_bound_search: FAILED **");
      $finish;
    end
  end

  initial begin
    // Directed: a short table with duplicates and both word extremes
    queue_write(0, 16'h0000, 1'b0);
    queue_write(1, 16'h0005, 1'b0);
    queue_write(2, 16'h0005, 1'b0);
    queue_write(3, 16'h1234, 1'b0);
    queue_write(4, 16'h8000, 1'b0);
    queue_write(5, 16'hABCD, 1'b0);
    queue_write(6, 16'hFFFE, 1'b0);
    queue_write(7, 16'hFFFF, 1'b0);
    queue_search(16'h0000, 0, 8);
    queue_search(16'h0005, 0, 8);
    queue_search(16'h0006, 0, 8);
    queue_search(16'hFFFF, 0, 8);
    queue_search(16'hFFFF, 0, 7);
    queue_search(16'h8000, 2, 6);
    queue_search(16'h9000, 5, 5);
    queue_search(16'h0000, 6, 2);
    queue_search(16'h5555, 127, 100);
    queue_search(16'h2AAA, 70, 3);
    queue_search(16'h0001, 0, 1);
    queue_search(16'hFFFF, 7, 8);
    // Last entry, reached through a saturated upper end
    queue_write(DEPTH - 1, 16'hFFFF, 1'b1);
    queue_search(16'hFFFF, DEPTH - 1, 127);
    queue_search(16'h0000, DEPTH, 127);

    // Random: full refills of the table, each followed by mixed traffic
    for (int r = 0; r < FILL_ROUNDS; r++) begin
      refill_table(r);
      queue_mixed(MIXED_ITEMS);
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Drain: all items sent, all lookups answered, then settle
    while (cmd_queue.size() != 0 || expected_lookups.size() != 0) @(posedge clk);
    repeat (24) @(posedge clk);

    $display("Covered %0d table writes and %0d searches over %0d table shapes.",
             writes_queued, searches_queued, FILL_ROUNDS);
    $display("Compared %0d results, including empty, inverted and saturated ranges.",
             lookups_checked);
    if (mismatch_count == 0) begin
      $display("** sorted_table_lower_bound_search: PASSED **");
    end else begin
      $display("** sorted_table_lower_bound_search: FAILED **");
    end
    $finish;
  end

endmodule

>>> sim.f
src/stlb_pkg.sv
src/stlb_ram.sv
src/stlb_datapath.sv
src/stlb_ctrl.sv
src/sorted_table_lower_bound_search.sv
src/stlb_checker.sv
tb/tb_sorted_table_lower_bound_search.sv
